// File: hw/rtl/ulsr_pkg.sv
// ----------------------------------------------------------------------------
// ulsr_pkg
// types and constants shared by the under-frequency load-shed relay
// ----------------------------------------------------------------------------
package ulsr_pkg;

	localparam int FREQ_W  = 22;
	localparam int RATE_W  = 25;
	localparam int LOADS_W = 5;
	localparam int DP_W    = 68;          // shared add/sub width
	localparam int QUO_W   = 59;          // rate quotient width

	// sample clock 16000 times 256
	localparam logic [FREQ_W-1:0] FDIV_NUM     = 22'd4096000;
	localparam logic [QUO_W-1:0]  RATE_POS_CAP = 59'd25600;
	localparam logic [QUO_W-1:0]  RATE_NEG_CAP = 59'd16777216;

	typedef enum logic [1:0] {
		CMD_SAMPLE = 2'd0,
		CMD_TICK   = 2'd1,
		CMD_SWITCH = 2'd2,
		CMD_NONE   = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		ACT_NONE      = 2'd0,
		ACT_SHED      = 2'd1,
		ACT_RECONNECT = 2'd2
	} act_t;

	typedef enum logic [1:0] {
		CFG_LOW_FREQ = 2'd0,
		CFG_ROC      = 2'd1,
		CFG_INTERVAL = 2'd2,
		CFG_UNUSED   = 2'd3
	} cfg_idx_t;

	typedef enum logic [3:0] {
		AR_IDLE, AR_FDIV, AR_SUM, AR_DIFA, AR_DIFB,
		AR_MUL1, AR_MUL2, AR_RDIV, AR_DONE
	} arith_state_t;

	typedef enum logic [1:0] {
		TS_IDLE, TS_RUN, TS_FIN
	} top_state_t;

	typedef struct packed {
		logic        start;
		logic [15:0] count;
	} arith_req_t;

	typedef struct packed {
		logic              done;
		logic [FREQ_W-1:0] freq;
		logic [QUO_W-1:0]  mag;
		logic              neg;
	} arith_rsp_t;

endpackage

// File: hw/rtl/ulsr_if.sv
// ----------------------------------------------------------------------------
// ulsr channel interfaces
// input, result and configuration channels with valid/ready
// ----------------------------------------------------------------------------
interface ulsr_in_if;
	logic        valid;
	logic        ready;
	logic [1:0]  command;
	logic [15:0] period_count;
	logic [4:0]  switch_mask;
	modport source (output valid, command, period_count, switch_mask, input ready);
	modport sink   (input valid, command, period_count, switch_mask, output ready);
endinterface

interface ulsr_out_if;
	logic               valid;
	logic               ready;
	logic [21:0]        frequency;
	logic signed [24:0] rate_of_change;
	logic               is_stable;
	logic [4:0]         connected_mask;
	logic [4:0]         shed_mask;
	logic [1:0]         action;
	modport source (output valid, frequency, rate_of_change, is_stable,
		connected_mask, shed_mask, action, input ready);
	modport sink   (input valid, frequency, rate_of_change, is_stable,
		connected_mask, shed_mask, action, output ready);
endinterface

interface ulsr_cfg_if;
	logic        valid;
	logic        ready;
	logic [1:0]  index;
	logic [15:0] data;
	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

// File: hw/rtl/ulsr_addsub.sv
// ----------------------------------------------------------------------------
// ulsr_addsub
// shared adder/subtractor, top bit flags a borrow on subtract
// ----------------------------------------------------------------------------
module ulsr_addsub
	import ulsr_pkg::*;
(
	input  logic [DP_W-1:0] a,
	input  logic [DP_W-1:0] b,
	input  logic            sub,
	output logic [DP_W:0]   res
);

	assign res = {1'b0, a} + ({1'b0, b} ^ {(DP_W+1){sub}}) + {{DP_W{1'b0}}, sub};

endmodule

// File: hw/rtl/ulsr_arith.sv
// ----------------------------------------------------------------------------
// ulsr_arith
// sequencer for frequency and rate of change on one shared add/sub
// ----------------------------------------------------------------------------
module ulsr_arith
	import ulsr_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  arith_req_t        req,
	input  logic [FREQ_W-1:0] prev_freq,
	output arith_rsp_t        rsp
);

	arith_state_t state_q, state_d;

	logic [FREQ_W-1:0] f_q;
	logic [FREQ_W:0]   s_q;
	logic [FREQ_W-1:0] d_q;
	logic              neg_q;
	logic [FREQ_W:0]   rem_q;
	logic [FREQ_W:0]   div_q;
	logic [DP_W-1:0]   quo_q;
	logic [DP_W-1:0]   acc_q;
	logic [DP_W-1:0]   opd_q;
	logic [6:0]        cnt_q;

	logic [DP_W-1:0] op_a, op_b;
	logic            op_sub;
	logic [DP_W:0]   res;

	logic [23:0]     rsh;
	logic            dneg;
	logic [DP_W-1:0] quo_div;
	logic [DP_W-1:0] acc_mul;

	ulsr_addsub u_addsub (.a(op_a), .b(op_b), .sub(op_sub), .res(res));

	assign rsh     = {rem_q, quo_q[DP_W-1]};
	assign dneg    = res[DP_W];
	assign quo_div = {quo_q[DP_W-2:0], ~dneg};
	assign acc_mul = quo_q[0] ? res[DP_W-1:0] : acc_q;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			AR_IDLE: if (req.start) state_d = AR_FDIV;
			AR_FDIV: if (cnt_q == 7'd0) state_d = AR_SUM;
			AR_SUM:  state_d = AR_DIFA;
			AR_DIFA: state_d = dneg ? AR_DIFB : AR_MUL1;
			AR_DIFB: state_d = AR_MUL1;
			AR_MUL1: if (cnt_q == 7'd0) state_d = AR_MUL2;
			AR_MUL2: if (cnt_q == 7'd0) state_d = AR_RDIV;
			AR_RDIV: if (cnt_q == 7'd0) state_d = AR_DONE;
			AR_DONE: state_d = AR_IDLE;
			default: state_d = AR_IDLE;
		endcase
	end

	// shared unit operands
	always_comb begin
		op_a   = '0;
		op_b   = '0;
		op_sub = 1'b0;
		unique case (state_q)
			AR_FDIV, AR_RDIV: begin
				op_a   = {{(DP_W-24){1'b0}}, rsh};
				op_b   = {{(DP_W-FREQ_W-1){1'b0}}, div_q};
				op_sub = 1'b1;
			end
			AR_SUM: begin
				op_a = {{(DP_W-FREQ_W){1'b0}}, f_q};
				op_b = {{(DP_W-FREQ_W){1'b0}}, prev_freq};
			end
			AR_DIFA: begin
				op_a   = {{(DP_W-FREQ_W){1'b0}}, f_q};
				op_b   = {{(DP_W-FREQ_W){1'b0}}, prev_freq};
				op_sub = 1'b1;
			end
			AR_DIFB: begin
				op_a   = {{(DP_W-FREQ_W){1'b0}}, prev_freq};
				op_b   = {{(DP_W-FREQ_W){1'b0}}, f_q};
				op_sub = 1'b1;
			end
			AR_MUL1, AR_MUL2: begin
				op_a = acc_q;
				op_b = opd_q;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= AR_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			unique case (state_q)
				AR_IDLE: if (req.start) cnt_q <= 7'd21;
				AR_DIFA: if (!dneg) cnt_q <= 7'd21;
				AR_DIFB: cnt_q <= 7'd21;
				AR_MUL1: cnt_q <= (cnt_q == 7'd0) ? 7'd21 : cnt_q - 7'd1;
				AR_MUL2: cnt_q <= (cnt_q == 7'd0) ? 7'(QUO_W-1) : cnt_q - 7'd1;
				AR_FDIV, AR_RDIV: if (cnt_q != 7'd0) cnt_q <= cnt_q - 7'd1;
				default: ;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			AR_IDLE: if (req.start) begin
				quo_q <= {FDIV_NUM, {(DP_W-FREQ_W){1'b0}}};
				rem_q <= '0;
				div_q <= (req.count == 16'd0) ? 23'd1 : {7'd0, req.count};
			end
			AR_FDIV: begin
				rem_q <= dneg ? rsh[FREQ_W:0] : res[FREQ_W:0];
				quo_q <= quo_div;
				if (cnt_q == 7'd0) f_q <= quo_div[FREQ_W-1:0];
			end
			AR_SUM: s_q <= res[FREQ_W:0];
			AR_DIFA: begin
				neg_q <= dneg;
				d_q   <= res[FREQ_W-1:0];
				acc_q <= '0;
				opd_q <= {{(DP_W-FREQ_W){1'b0}}, f_q};
				quo_q <= {{(DP_W-FREQ_W){1'b0}}, prev_freq};
			end
			AR_DIFB: begin
				d_q <= res[FREQ_W-1:0];
			end
			AR_MUL1: begin
				if (cnt_q == 7'd0) begin
					opd_q <= acc_mul;
					acc_q <= '0;
					quo_q <= {{(DP_W-FREQ_W){1'b0}}, d_q};
				end else begin
					acc_q <= acc_mul;
					opd_q <= {opd_q[DP_W-2:0], 1'b0};
					quo_q <= {1'b0, quo_q[DP_W-1:1]};
				end
			end
			AR_MUL2: begin
				if (cnt_q == 7'd0) begin
					// 2*d*f*p / 256 taken as product >> 7
					quo_q <= {acc_mul[QUO_W+6:7], {(DP_W-QUO_W){1'b0}}};
					rem_q <= '0;
					div_q <= s_q;
				end else begin
					acc_q <= acc_mul;
					opd_q <= {opd_q[DP_W-2:0], 1'b0};
					quo_q <= {1'b0, quo_q[DP_W-1:1]};
				end
			end
			AR_RDIV: begin
				rem_q <= dneg ? rsh[FREQ_W:0] : res[FREQ_W:0];
				quo_q <= quo_div;
			end
			default: ;
		endcase
	end

	assign rsp.done = (state_q == AR_DONE);
	assign rsp.freq = f_q;
	assign rsp.mag  = quo_q[QUO_W-1:0];
	assign rsp.neg  = neg_q;

endmodule

// File: hw/rtl/underfreq_load_shed_relay.sv
// ----------------------------------------------------------------------------
// underfreq_load_shed_relay
// under-frequency load-shedding relay with serial frequency/rate arithmetic
// ----------------------------------------------------------------------------
// usage
//   sample_in beats carry a command: analyser sample (period count), timer
//   tick, or switch update. every beat yields exactly one result_out beat
//   with the last frequency, rate, stability, load masks and the action.
//   cfg beats write low_freq_limit (0), roc_limit (1), shed_interval (2);
//   cfg is always ready; the user must write it only while the relay is idle, the block itself does not enforce this.
// arithmetic
//   a sample runs one restoring division for the frequency (22 steps),
//   sum and difference, two 22-step shift-add multiplies and a 59-step
//   division for the rate, all on one shared 68-bit add/sub unit. ticks
//   and switch updates skip the arithmetic.
//   sample_in is ready only while no beat is being worked on.
// reset
//   arst_n clears all relay state: limits return to 50.0 hz, 30 hz/s and
//   500 ticks, the relay reads stable with no loads connected or shed.
// stalls
//   one result register sits on result_out; a new beat is taken while a
//   result waits, and its result is held until the register frees up.
// ----------------------------------------------------------------------------
module underfreq_load_shed_relay
	import ulsr_pkg::*;
#(
	parameter int NUM_LOADS = 5
) (
	input  logic        clk,
	input  logic        arst_n,
	ulsr_in_if.sink     sample_in,
	ulsr_out_if.source  result_out,
	ulsr_cfg_if.sink    cfg
);

	// only the lowest five loads exist on the ports
	localparam int EFF_LOADS = (NUM_LOADS < LOADS_W) ? NUM_LOADS : LOADS_W;
	localparam logic [LOADS_W-1:0] LOAD_MASK = LOADS_W'((1 << EFF_LOADS) - 1);

	top_state_t state_q, state_d;

	// configuration
	logic [9:0]  low_freq_q;
	logic [7:0]  roc_limit_q;
	logic [15:0] interval_q;

	// relay state
	logic [FREQ_W-1:0]  prev_freq_q;
	logic [RATE_W-1:0]  rate_q;
	logic               stable_q;
	logic [15:0]        icount_q;
	logic               expired_q;
	logic [LOADS_W-1:0] conn_q;
	logic [LOADS_W-1:0] shed_q;
	logic [LOADS_W-1:0] sw_q;
	logic               seen_q;

	// latched beat
	cmd_t               cmd_q;
	logic [LOADS_W-1:0] mask_q;

	// result register
	logic               ov_q;
	logic [FREQ_W-1:0]  o_freq_q;
	logic [RATE_W-1:0]  o_rate_q;
	logic               o_stable_q;
	logic [LOADS_W-1:0] o_conn_q;
	logic [LOADS_W-1:0] o_shed_q;
	act_t               o_act_q;

	arith_req_t req;
	arith_rsp_t rsp;

	logic in_fire, can_load, fin_load;

	ulsr_arith u_arith (
		.clk(clk), .arst_n(arst_n), .req(req), .prev_freq(prev_freq_q), .rsp(rsp)
	);

	assign in_fire  = sample_in.valid && sample_in.ready;
	assign can_load = !ov_q || result_out.ready;
	assign fin_load = (state_q == TS_FIN) && can_load;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			TS_IDLE: if (in_fire)
				state_d = (cmd_t'(sample_in.command) == CMD_SAMPLE) ? TS_RUN : TS_FIN;
			TS_RUN:  if (rsp.done) state_d = TS_FIN;
			TS_FIN:  if (can_load) state_d = TS_IDLE;
			default: state_d = TS_IDLE;
		endcase
	end

	// handshake outputs
	always_comb begin
		sample_in.ready = (state_q == TS_IDLE);
		req.start       = in_fire && (cmd_t'(sample_in.command) == CMD_SAMPLE);
		req.count       = sample_in.period_count;
	end

	// rate capping and thresholds
	logic [QUO_W-1:0]  neg_cap;
	logic [RATE_W-1:0] mag;
	logic [RATE_W-1:0] rate_new;
	logic              stable_new;
	logic [25:0]       f_x10;

	always_comb begin
		neg_cap = (rsp.mag > RATE_NEG_CAP) ? RATE_NEG_CAP : rsp.mag;
		if (rsp.neg) begin
			mag      = neg_cap[RATE_W-1:0];
			rate_new = ~neg_cap[RATE_W-1:0] + RATE_W'(1);
		end else begin
			mag      = (rsp.mag > RATE_POS_CAP) ? RATE_POS_CAP[RATE_W-1:0]
				: rsp.mag[RATE_W-1:0];
			rate_new = mag;
		end
		f_x10      = {1'b0, rsp.freq, 3'b0} + {3'b0, rsp.freq, 1'b0};
		stable_new = !((mag > {10'd0, roc_limit_q, 7'd0})
			|| (f_x10 < {8'd0, low_freq_q, 8'd0}));
	end

	// next relay state for the latched command
	logic [RATE_W-1:0]  n_rate;
	logic [FREQ_W-1:0]  n_prev;
	logic               n_stable, n_expired, n_seen;
	logic [15:0]        n_icount;
	logic [LOADS_W-1:0] n_conn, n_shed, n_sw, pick, cand;
	act_t               n_act;

	always_comb begin
		n_rate    = rate_q;
		n_prev    = prev_freq_q;
		n_stable  = stable_q;
		n_expired = expired_q;
		n_icount  = icount_q;
		n_conn    = conn_q;
		n_shed    = shed_q;
		n_sw      = sw_q;
		n_seen    = seen_q;
		n_act     = ACT_NONE;
		pick      = '0;
		cand      = '0;
		case (cmd_q)
			CMD_SAMPLE: begin
				n_rate   = rate_new;
				n_prev   = rsp.freq;
				n_stable = stable_new;
				// stability change restarts the interval
				if (stable_new != stable_q) begin
					n_icount  = '0;
					n_expired = 1'b0;
				end
				if (n_expired || shed_q == '0) begin
					n_expired = 1'b0;
					n_icount  = '0;
					if (!stable_new) begin
						// lowest connected load goes
						pick = conn_q & (~conn_q + LOADS_W'(1));
						if (pick != '0) begin
							n_conn = conn_q & ~pick;
							n_shed = shed_q | pick;
							n_act  = ACT_SHED;
						end
					end else begin
						// highest switched-on idle load comes back
						cand = sw_q & ~conn_q;
						for (int i = 0; i < LOADS_W; i++) begin
							if (cand[i]) pick = LOADS_W'(1 << i);
						end
						if (pick != '0) begin
							n_conn = conn_q | pick;
							n_shed = shed_q & ~pick;
							n_act  = ACT_RECONNECT;
						end
					end
				end
			end
			CMD_TICK: begin
				if (!expired_q) begin
					if (icount_q != 16'hFFFF) n_icount = icount_q + 16'd1;
					if (n_icount >= interval_q) n_expired = 1'b1;
				end
			end
			CMD_SWITCH: begin
				if (!seen_q) begin
					n_conn = mask_q;
					n_shed = '0;
					n_seen = 1'b1;
				end else begin
					n_conn = conn_q & mask_q;
					n_shed = shed_q & mask_q;
				end
				n_sw = mask_q;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= TS_IDLE;
			low_freq_q  <= 10'd500;
			roc_limit_q <= 8'd60;
			interval_q  <= 16'd500;
			prev_freq_q <= '0;
			rate_q      <= '0;
			stable_q    <= 1'b1;
			icount_q    <= '0;
			expired_q   <= 1'b0;
			conn_q      <= '0;
			shed_q      <= '0;
			sw_q        <= '0;
			seen_q      <= 1'b0;
			ov_q        <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg.valid) begin
				unique case (cfg_idx_t'(cfg.index))
					CFG_LOW_FREQ: low_freq_q  <= cfg.data[9:0];
					CFG_ROC:      roc_limit_q <= cfg.data[7:0];
					CFG_INTERVAL: interval_q  <= cfg.data;
					default: ;
				endcase
			end
			if (fin_load) begin
				prev_freq_q <= n_prev;
				rate_q      <= n_rate;
				stable_q    <= n_stable;
				icount_q    <= n_icount;
				expired_q   <= n_expired;
				conn_q      <= n_conn;
				shed_q      <= n_shed;
				sw_q        <= n_sw;
				seen_q      <= n_seen;
				ov_q        <= 1'b1;
			end else if (result_out.ready) begin
				ov_q <= 1'b0;
			end
		end
	end

	// latched beat and result payload
	always_ff @(posedge clk) begin
		if (in_fire) begin
			cmd_q  <= cmd_t'(sample_in.command);
			mask_q <= sample_in.switch_mask & LOAD_MASK;
		end
		if (fin_load) begin
			o_freq_q   <= n_prev;
			o_rate_q   <= n_rate;
			o_stable_q <= n_stable;
			o_conn_q   <= n_conn;
			o_shed_q   <= n_shed;
			o_act_q    <= n_act;
		end
	end

	assign cfg.ready                 = 1'b1;
	assign result_out.valid          = ov_q;
	assign result_out.frequency      = o_freq_q;
	assign result_out.rate_of_change = o_rate_q;
	assign result_out.is_stable      = o_stable_q;
	assign result_out.connected_mask = o_conn_q;
	assign result_out.shed_mask      = o_shed_q;
	assign result_out.action         = o_act_q;

endmodule
